### hw/rtl/mdk_pkg.sv
// Shared types, register codes and fixed-point helpers for the mecanum kinematics core.
`default_nettype none

package mdk_pkg;

	localparam int unsigned FieldW    = 16;
	localparam int unsigned NumFields = 7;
	localparam int unsigned DataW     = FieldW * NumFields;
	localparam int unsigned CfgIdxW   = 3;
	localparam int unsigned CfgDataW  = 16;
	localparam int unsigned Latency   = 7;

	localparam logic [CfgIdxW-1:0] CFG_INV_WHEEL_RADIUS = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_LEVER_SUM        = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_RADIUS_QUARTER   = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_INV_LEVER_SUM    = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_MAX_LINEAR       = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_MAX_ANGULAR      = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_DRIVE_GAIN       = 3'd6;

	localparam logic [15:0] RST_INV_WHEEL_RADIUS = 16'd256;
	localparam logic [15:0] RST_LEVER_SUM        = 16'd256;
	localparam logic [15:0] RST_RADIUS_QUARTER   = 16'd64;
	localparam logic [15:0] RST_INV_LEVER_SUM    = 16'd256;
	localparam logic [14:0] RST_MAX_LINEAR       = 15'd32767;
	localparam logic [14:0] RST_MAX_ANGULAR      = 15'd32767;
	localparam logic [15:0] RST_DRIVE_GAIN       = 16'd77;

	typedef struct packed {
		logic [15:0] inv_wheel_radius;
		logic [15:0] lever_sum;
		logic [15:0] radius_quarter;
		logic [15:0] inv_lever_sum;
		logic [14:0] max_linear;
		logic [14:0] max_angular;
		logic [15:0] drive_gain;
	} cfg_t;

	// first stage: clamped targets, signed wheel sums and the yaw gain product
	typedef struct packed {
		logic signed [16:0] lin_p;
		logic signed [16:0] lin_m;
		logic signed [15:0] cw;
		logic signed [17:0] sum_x;
		logic signed [17:0] sum_y;
		logic signed [17:0] sum_w;
		logic [31:0]        k_wz;
	} s1_t;

	function automatic logic signed [15:0] sat16(input logic signed [47:0] x);
		logic signed [15:0] r;
		if (x > 48'sd32767) begin
			r = 16'sh7fff;
		end else if (x < -48'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = x[15:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] clamp_sym(input logic signed [15:0] v,
			input logic [14:0] lim);
		logic signed [15:0] l;
		logic signed [15:0] r;
		l = $signed({1'b0, lim});
		if (v > l) begin
			r = l;
		end else if (v < -l) begin
			r = -l;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/mdk_front.sv
// First stage: clamps the targets, forms the linear and wheel sums and the yaw gain.
`default_nettype none

module mdk_front
	import mdk_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [DataW-1:0] in_data,
	input  cfg_t             cfg,
	output s1_t              s1
);

	logic signed [15:0] vx, vy, wz, m1, m2, m3, m4;
	logic signed [15:0] cx, cy, cw;
	s1_t                nxt;

	always_comb begin
		vx = $signed(in_data[15:0]);
		vy = $signed(in_data[31:16]);
		wz = $signed(in_data[47:32]);
		m1 = $signed(in_data[63:48]);
		m2 = $signed(in_data[79:64]);
		m3 = $signed(in_data[95:80]);
		m4 = $signed(in_data[111:96]);
		cx = clamp_sym(vx, cfg.max_linear);
		cy = clamp_sym(vy, cfg.max_linear);
		cw = clamp_sym(wz, cfg.max_angular);
		nxt.lin_p = 17'(cx) + 17'(cy);
		nxt.lin_m = 17'(cx) - 17'(cy);
		nxt.cw    = cw;
		nxt.sum_x = 18'(m1) + 18'(m2) + 18'(m3) + 18'(m4);
		nxt.sum_y = 18'(m1) - 18'(m2) - 18'(m3) + 18'(m4);
		nxt.sum_w = 18'(m2) + 18'(m4) - 18'(m1) - 18'(m3);
		nxt.k_wz  = cfg.radius_quarter * cfg.inv_lever_sum;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/mdk_inverse.sv
// Inverse kinematics: wheel speed targets and drive commands, stages two to seven.
`default_nettype none

module mdk_inverse
	import mdk_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  s1_t         s1,
	input  cfg_t        cfg,
	output logic [63:0] pwm_s7
);

	logic signed [32:0] rot_s2;
	logic signed [16:0] lin_p_s2, lin_m_s2;
	logic signed [33:0] a_s3    [4];
	logic signed [50:0] prod_s4 [4];
	logic signed [35:0] w_s5    [4];
	logic signed [52:0] pp_s6   [4];

	logic signed [33:0] lp, lm, rot;
	logic signed [33:0] a_nxt   [4];
	logic signed [51:0] w_rnd   [4];
	logic signed [53:0] p_rnd   [4];
	logic [63:0]        pwm_nxt;

	always_comb begin
		lp = 34'($signed({lin_p_s2, 8'd0}));
		lm = 34'($signed({lin_m_s2, 8'd0}));
		rot = 34'(rot_s2);
		// front left, front right, rear left, rear right
		a_nxt[0] = lp - rot;
		a_nxt[1] = lm + rot;
		a_nxt[2] = lm - rot;
		a_nxt[3] = lp + rot;
		for (int i = 0; i < 4; i++) begin
			w_rnd[i] = 52'(prod_s4[i]) + 52'sd32768;
			p_rnd[i] = 54'(pp_s6[i]) + 54'sd128;
			pwm_nxt[i*16 +: 16] = sat16(48'(p_rnd[i] >>> 8));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s2   <= $signed({1'b0, cfg.lever_sum}) * s1.cw;
			lin_p_s2 <= s1.lin_p;
			lin_m_s2 <= s1.lin_m;
			for (int i = 0; i < 4; i++) begin
				a_s3[i]    <= a_nxt[i];
				prod_s4[i] <= a_s3[i] * $signed({1'b0, cfg.inv_wheel_radius});
				w_s5[i]    <= 36'(w_rnd[i] >>> 16);
				pp_s6[i]   <= w_s5[i] * $signed({1'b0, cfg.drive_gain});
			end
			pwm_s7 <= pwm_nxt;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/mdk_forward.sv
// Forward kinematics: body velocity from measured wheel sums, delayed to match the wheel path.
`default_nettype none

module mdk_forward
	import mdk_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  s1_t         s1,
	input  cfg_t        cfg,
	output logic [47:0] body_s7
);

	logic signed [34:0] px_s2, py_s2;
	logic signed [50:0] pw_s2;
	logic [47:0]        body_s3, body_s4, body_s5, body_s6;

	logic signed [35:0] rx, ry;
	logic signed [51:0] rw;
	logic [47:0]        body_nxt;

	always_comb begin
		rx = 36'(px_s2) + 36'sd128;
		ry = 36'(py_s2) + 36'sd128;
		rw = 52'(pw_s2) + 52'sd32768;
		body_nxt[15:0]  = sat16(48'(rx >>> 8));
		body_nxt[31:16] = sat16(48'(ry >>> 8));
		body_nxt[47:32] = sat16(48'(rw >>> 16));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2   <= $signed({1'b0, cfg.radius_quarter}) * s1.sum_x;
			py_s2   <= $signed({1'b0, cfg.radius_quarter}) * s1.sum_y;
			pw_s2   <= $signed({1'b0, s1.k_wz}) * s1.sum_w;
			body_s3 <= body_nxt;
			body_s4 <= body_s3;
			body_s5 <= body_s4;
			body_s6 <= body_s5;
			body_s7 <= body_s6;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/mecanum_drive_kinematics_core.sv
// Mecanum drive kinematics core: handshake, register file and pipeline control.
// An accepted request reaches m_axis_tvalid through the seven pipeline stages
// (clamp, lever product, wheel sum, radius multiply, round, PWM multiply, round
// and saturate). Throughput: one request per cycle unless the output stalls.
// Output back-pressure stalls all stages together; nothing is dropped.
// Reset loads the register defaults and clears the valid bits; data is not reset.
`default_nettype none

module mecanum_drive_kinematics_core
	import mdk_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// target_vx, target_vy, target_wz, measured_front_left, measured_front_right,
	// measured_rear_left, measured_rear_right (16 bits each, lowest first)
	input  logic [DataW-1:0]    s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// pwm_front_left, pwm_front_right, pwm_rear_left, pwm_rear_right,
	// body_vx, body_vy, body_wz (16 bits each, lowest first)
	output logic [DataW-1:0]    m_axis_tdata,
	input  logic                cfg_wen,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t               cfg_q;
	logic [Latency-1:0] vld_q;
	logic               adv;
	s1_t                s1;
	logic [63:0]        pwm;
	logic [47:0]        body;

	assign adv           = !vld_q[Latency-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[Latency-1];
	assign m_axis_tdata  = {body, pwm};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_wheel_radius <= RST_INV_WHEEL_RADIUS;
			cfg_q.lever_sum        <= RST_LEVER_SUM;
			cfg_q.radius_quarter   <= RST_RADIUS_QUARTER;
			cfg_q.inv_lever_sum    <= RST_INV_LEVER_SUM;
			cfg_q.max_linear       <= RST_MAX_LINEAR;
			cfg_q.max_angular      <= RST_MAX_ANGULAR;
			cfg_q.drive_gain       <= RST_DRIVE_GAIN;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_INV_WHEEL_RADIUS: cfg_q.inv_wheel_radius <= cfg_data;
				CFG_LEVER_SUM:        cfg_q.lever_sum        <= cfg_data;
				CFG_RADIUS_QUARTER:   cfg_q.radius_quarter   <= cfg_data;
				CFG_INV_LEVER_SUM:    cfg_q.inv_lever_sum    <= cfg_data;
				CFG_MAX_LINEAR:       cfg_q.max_linear       <= cfg_data[14:0];
				CFG_MAX_ANGULAR:      cfg_q.max_angular      <= cfg_data[14:0];
				CFG_DRIVE_GAIN:       cfg_q.drive_gain       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Latency-2:0], s_axis_tvalid};
		end
	end

	mdk_front u_front (
		.clk     (clk),
		.en      (adv),
		.in_data (s_axis_tdata),
		.cfg     (cfg_q),
		.s1      (s1)
	);

	mdk_inverse u_inverse (
		.clk    (clk),
		.en     (adv),
		.s1     (s1),
		.cfg    (cfg_q),
		.pwm_s7 (pwm)
	);

	mdk_forward u_forward (
		.clk     (clk),
		.en      (adv),
		.s1      (s1),
		.cfg     (cfg_q),
		.body_s7 (body)
	);

endmodule

`default_nettype wire

### hw/rtl/mdk_checker.sv
// Port-level checks for the mecanum kinematics core, bound to the top level.
`default_nettype none

module mdk_checker
	import mdk_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [DataW-1:0] m_axis_tdata
);

	logic       acc, dlv;
	logic [3:0] occ_q;
	logic [2:0] age_q;

	assign acc = s_axis_tvalid && s_axis_tready;
	assign dlv = m_axis_tvalid && m_axis_tready;

	// requests in flight, and edges since reset (saturating)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			age_q <= '0;
		end else begin
			occ_q <= occ_q + 4'(acc) - 4'(dlv);
			if (age_q != 3'd7) begin
				age_q <= age_q + 3'd1;
			end
		end
	end

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (occ_q != 4'd0 && occ_q <= 4'd7))
		else $error("result without a request in flight");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(age_q == 3'd7 && $past(acc, 7) && $past(m_axis_tready, 1)
			&& $past(m_axis_tready, 2) && $past(m_axis_tready, 3)
			&& $past(m_axis_tready, 4) && $past(m_axis_tready, 5)
			&& $past(m_axis_tready, 6)) |-> m_axis_tvalid)
		else $error("result late without back-pressure");

endmodule

bind mecanum_drive_kinematics_core mdk_checker u_mdk_checker (.*);

`default_nettype wire

### bench/mecanum_drive_kinematics_core_tb.sv
// Self-checking testbench for the mecanum kinematics core: scoreboard, stimulus and checks.

class kinematics_scoreboard;
	typedef struct packed {
		logic signed [15:0] rear_right;
		logic signed [15:0] rear_left;
		logic signed [15:0] front_right;
		logic signed [15:0] front_left;
		logic signed [15:0] wz;
		logic signed [15:0] vy;
		logic signed [15:0] vx;
	} target_set_t;

	typedef struct packed {
		logic signed [15:0] body_wz;
		logic signed [15:0] body_vy;
		logic signed [15:0] body_vx;
		logic signed [15:0] pwm_rr;
		logic signed [15:0] pwm_rl;
		logic signed [15:0] pwm_fr;
		logic signed [15:0] pwm_fl;
	} drive_cmd_t;

	logic [15:0] inv_radius;
	logic [15:0] lever;
	logic [15:0] radius_q;
	logic [15:0] inv_lever;
	logic [14:0] lim_linear;
	logic [14:0] lim_angular;
	logic [15:0] pwm_gain;
	drive_cmd_t  pending[$];
	int          errors;
	int          requests;
	int          results;
	string       field_name[7];

	function new();
		field_name = '{"pwm_front_left", "pwm_front_right", "pwm_rear_left", "pwm_rear_right",
			"body_vx", "body_vy", "body_wz"};
		inv_radius  = mdk_pkg::RST_INV_WHEEL_RADIUS;
		lever       = mdk_pkg::RST_LEVER_SUM;
		radius_q    = mdk_pkg::RST_RADIUS_QUARTER;
		inv_lever   = mdk_pkg::RST_INV_LEVER_SUM;
		lim_linear  = mdk_pkg::RST_MAX_LINEAR;
		lim_angular = mdk_pkg::RST_MAX_ANGULAR;
		pwm_gain    = mdk_pkg::RST_DRIVE_GAIN;
		errors      = 0;
		requests    = 0;
		results     = 0;
	endfunction

	function void set_reg(logic [mdk_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
		case (idx)
			mdk_pkg::CFG_INV_WHEEL_RADIUS: inv_radius = val;
			mdk_pkg::CFG_LEVER_SUM:        lever = val;
			mdk_pkg::CFG_RADIUS_QUARTER:   radius_q = val;
			mdk_pkg::CFG_INV_LEVER_SUM:    inv_lever = val;
			mdk_pkg::CFG_MAX_LINEAR:       lim_linear = val[14:0];
			mdk_pkg::CFG_MAX_ANGULAR:      lim_angular = val[14:0];
			mdk_pkg::CFG_DRIVE_GAIN:       pwm_gain = val;
			default: ;
		endcase
	endfunction

	// round half up: add half an LSB, then arithmetic shift (floor)
	function longint rnd_shift(longint x, int sh);
		return (x + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function logic signed [15:0] sat_q78(longint x);
		if (x > 32767)
			return 16'sh7fff;
		if (x < -32768)
			return 16'sh8000;
		return x[15:0];
	endfunction

	function longint clamp_lim(longint v, logic [14:0] lim);
		longint l;
		l = lim;
		if (v > l)
			return l;
		if (v < -l)
			return -l;
		return v;
	endfunction

	function logic signed [15:0] wheel_pwm(longint lin, longint rot);
		longint a;
		longint w;
		a = lin * 256 + rot;
		w = rnd_shift(a * longint'(inv_radius), 16);
		return sat_q78(rnd_shift(w * longint'(pwm_gain), 8));
	endfunction

	function void note_request(logic [mdk_pkg::DataW-1:0] d);
		target_set_t t;
		drive_cmd_t  r;
		longint      cx, cy, cw, rot, rq, m1, m2, m3, m4;
		t   = d;
		cx  = clamp_lim(t.vx, lim_linear);
		cy  = clamp_lim(t.vy, lim_linear);
		cw  = clamp_lim(t.wz, lim_angular);
		m1  = t.front_left;
		m2  = t.front_right;
		m3  = t.rear_left;
		m4  = t.rear_right;
		rot = longint'(lever) * cw;
		rq  = longint'(radius_q);
		r.pwm_fl  = wheel_pwm(cx + cy, -rot);
		r.pwm_fr  = wheel_pwm(cx - cy, rot);
		r.pwm_rl  = wheel_pwm(cx - cy, -rot);
		r.pwm_rr  = wheel_pwm(cx + cy, rot);
		r.body_vx = sat_q78(rnd_shift(rq * (m1 + m2 + m3 + m4), 8));
		r.body_vy = sat_q78(rnd_shift(rq * (m1 - m2 - m3 + m4), 8));
		r.body_wz = sat_q78(rnd_shift(rq * longint'(inv_lever) * (-m1 + m2 - m3 + m4), 16));
		pending.push_back(r);
		requests++;
	endfunction

	task report(string msg);
		errors++;
		$display("mismatch: %s", msg);
	endtask

	task check_result(logic [mdk_pkg::DataW-1:0] d);
		drive_cmd_t                 want;
		logic [mdk_pkg::DataW-1:0]  w;
		results++;
		if (pending.size() == 0) begin
			report($sformatf("result %h with no request outstanding", d));
			return;
		end
		want = pending.pop_front();
		w    = want;
		for (int i = 0; i < 7; i++) begin
			if (d[16*i +: 16] !== w[16*i +: 16])
				report($sformatf("result %0d %s: got %h, expected %h", results, field_name[i],
					d[16*i +: 16], w[16*i +: 16]));
		end
	endtask
endclass

module mecanum_drive_kinematics_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mdk_pkg::*;

	localparam logic [CfgIdxW-1:0] CFG_NONE = 3'd7;  // decodes to no register
	localparam int IDLE_LIMIT  = 1000;
	localparam int HOLD_CYCLES = 120;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [DataW-1:0]    s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [DataW-1:0]    m_axis_tdata;
	logic                cfg_wen = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	kinematics_scoreboard sb = new();
	int   src_idle_pct = 34;
	int   sink_idle_pct = 81;
	logic hold_toggle = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;
	int   quiet = 0;

	mecanum_drive_kinematics_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_request(s_axis_tdata);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// receiver: random stalls, plus a long hold-off whenever hold_toggle flips
	always @(posedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen     <= hold_toggle;
			hold_left     <= HOLD_CYCLES - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wen) begin
			quiet <= 0;
		end else if (quiet >= IDLE_LIMIT) begin
			$display("mecanum_drive_kinematics_core_tb: errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [DataW-1:0] pack(input logic [15:0] vx, vy, wz, fl, fr, rl, rr);
		return {rr, rl, fr, fl, wz, vy, vx};
	endfunction

	// corner-heavy field values; the default case draws from the full 16-bit range
	function automatic logic [15:0] rand_field();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			4: return 16'($urandom_range(1023) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [DataW-1:0] rand_request();
		logic [DataW-1:0] d;
		for (int i = 0; i < NumFields; i++)
			d[16*i +: 16] = rand_field();
		return d;
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(5))
			0: return 16'hffff;
			1: return 16'h0000;
			2, 3: return 16'($urandom_range(32, 1024));
			default: return 16'($urandom);
		endcase
	endfunction

	// limits are 15 bits; values with bit 15 set check the masking
	function automatic logic [15:0] rand_limit();
		case ($urandom_range(5))
			0: return 16'h7fff;
			1: return 16'h0000;
			2: return 16'hffff;
			3, 4: return 16'($urandom_range(64, 8192));
			default: return 16'($urandom);
		endcase
	endfunction

	// each cycle before offering, the sender idles with the set percentage
	task automatic send_request(input logic [DataW-1:0] d);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (Latency + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic load_config(input logic [15:0] inv_r, lev, rq, inv_lev, lin, ang, gain);
		write_reg(CFG_INV_WHEEL_RADIUS, inv_r);
		write_reg(CFG_LEVER_SUM, lev);
		write_reg(CFG_RADIUS_QUARTER, rq);
		write_reg(CFG_INV_LEVER_SUM, inv_lev);
		write_reg(CFG_MAX_LINEAR, lin);
		write_reg(CFG_MAX_ANGULAR, ang);
		write_reg(CFG_DRIVE_GAIN, gain);
	endtask

	initial begin
		int n_cfg;
		n_cfg = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: unit moves along each axis, extremes, one-LSB rounding
		send_request(pack(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_request(pack(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
		send_request(pack(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
		send_request(pack(16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0100, 16'h0100));
		send_request(pack(16'h0000, 16'h0100, 16'h0000, 16'h0100, 16'hff00, 16'hff00, 16'h0100));
		send_request(pack(16'h0000, 16'h0000, 16'h0100, 16'hff00, 16'h0100, 16'hff00, 16'h0100));
		send_request(pack(16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
		send_request(pack(16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff));
		drain_results();

		// largest coefficients: wide intermediates, outputs saturate
		load_config(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		n_cfg++;
		send_request(pack(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
		send_request(pack(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
		send_request(pack(16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000));
		drain_results();

		// zero limits force targets to zero; zero gains kill every term;
		// a write to the unused index must change nothing
		load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		write_reg(CFG_NONE, 16'hffff);
		n_cfg++;
		send_request(pack(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
		send_request(pack(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
		drain_results();

		// tight limits with plausible gains: clamp on both sides and at the edge
		load_config(16'h0a00, 16'h0040, 16'h0010, 16'h0400, 16'h0200, 16'h0080, 16'h004d);
		n_cfg++;
		send_request(pack(16'h0300, 16'hfd00, 16'h0100, 16'h1234, 16'hedcc, 16'h0777, 16'hf889));
		send_request(pack(16'hfe00, 16'h0200, 16'hff80, 16'h0200, 16'h0200, 16'hfe00, 16'hfe00));
		send_request(pack(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h0000, 16'h7fff, 16'h0001));
		drain_results();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 34;
					sink_idle_pct <= 81;
				end
				1: begin
					src_idle_pct = 81;
					sink_idle_pct <= 34;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct <= 0;
				end
			endcase
			for (int part = 0; part < 2; part++) begin
				load_config(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
					rand_limit(), rand_limit(), rand_coef());
				n_cfg++;
				// long output stall while requests keep coming: pipeline fills, input backs up
				if (ph == 2 && part == 0)
					hold_toggle <= ~hold_toggle;
				repeat (140) send_request(rand_request());
				drain_results();
			end
		end

		if (sb.pending.size() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));
		$display("covered %0d requests, %0d results, %0d register settings", sb.requests,
			sb.results, n_cfg);
		$display("idle mixes: sender-heavy, receiver-heavy, none; one long output hold-off");
		if (sb.errors == 0) begin
			$display("mecanum_drive_kinematics_core_tb: clean");
		end else begin
			$display("mecanum_drive_kinematics_core_tb: errors");
		end
		$finish;
	end
endmodule
